/* rtl/kmer_bucket_histogram_top_macros.svh */
// Assertion macros used by the histogram top level.
`ifndef KMER_BUCKET_HISTOGRAM_TOP_MACROS_SVH
`define KMER_BUCKET_HISTOGRAM_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KBH_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KBH_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* rtl/kbh_pkg.sv */
// Shared constants, types and helpers of the k-mer bucket histogram.
package kbh_pkg;

  localparam int unsigned TABLE_DEPTH = 1048576;
  localparam int unsigned MAX_WORD    = 4;

  localparam int SYM_W      = 8;
  localparam int ALPHA_W    = 7;
  localparam int WLEN_W     = 3;
  localparam int SEQ_W      = 32;
  localparam int INDEX_W    = 20;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int WORD_W    = MAX_WORD * ALPHA_W;
  localparam int CMP_W     = (WORD_W > 32) ? WORD_W : 32;
  localparam int CNT_W     = $clog2(MAX_WORD + 1);
  localparam int WIN_IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  localparam logic [ALPHA_W-1:0] ALPHABET_RESET = ALPHA_W'(6);
  localparam logic [WLEN_W-1:0]  WLEN_RESET     = WLEN_W'(4);
  localparam logic [SEQ_W-1:0]   SEQ_RESET      = '0;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = CFG_IDX_W'(2);

  typedef struct packed {
    logic                      operation;
    logic signed [SYM_W-1:0]   symbol;
    logic [INDEX_W-1:0]        bucket_select;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bucket_index;
    logic [COUNT_W-1:0] bin_count;
    logic               counted;
    logic               out_of_range;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic step;
  } word_ctrl_t;

  typedef struct packed {
    logic eval;
    logic first_ok;
    logic done;
  } word_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

/* rtl/kmer_bucket_histogram_top.sv */
// Top level of the k-mer bucket histogram: control, bin store and result register.
`include "kmer_bucket_histogram_top_macros.svh"

// Counts how many window start positions begin with each word of word_length
// symbols; bins live in one 32-bit RAM with registered reads. After reset a
// clearing pass writes zero to every bin, one per cycle, through all
// TABLE_DEPTH (1048576) bins; no item is taken during it, configuration
// writes are. One item is worked on at a time: a read passes IDLE and DONE,
// a push with no evaluated window IDLE, MAC and DONE, and an evaluated push
// also steps in MAC, building its word number one symbol per cycle through a
// single multiply-add, before the bin's read-modify-write. The bin write
// lands before the next item can issue its read, so no forwarding is needed.
// The result register lets the next item start while a result waits.
module kmer_bucket_histogram_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  kbh_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output kbh_pkg::rsp_t                  rsp,
  input  logic                           cfg_we,
  input  logic [kbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kbh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kbh_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   clr_addr_next;
  logic [ALPHA_W-1:0]  alphabet_size;
  logic [WLEN_W-1:0]   word_length;
  logic [SEQ_W-1:0]    sequence_length;
  logic                accept;
  logic                op_q;
  logic [INDEX_W-1:0]  sel_q;
  logic                oor_q;
  logic                oor_next;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [COUNT_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [COUNT_W-1:0]  ram_rdata;
  word_ctrl_t          wu_ctrl;
  word_stat_t          wu_stat;
  logic [WORD_W-1:0]   wu_word;
  logic                word_oor;
  logic                sel_ok;
  logic                load_rsp;
  rsp_t                rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size   <= ALPHABET_RESET;
      word_length     <= WLEN_RESET;
      sequence_length <= SEQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHABET_SIZE:   alphabet_size   <= cfg_data[ALPHA_W-1:0];
        REG_WORD_LENGTH:     word_length     <= cfg_data[WLEN_W-1:0];
        REG_SEQUENCE_LENGTH: sequence_length <= cfg_data[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  kbh_word_unit u_word (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (wu_ctrl),
    .symbol          (req.symbol),
    .alphabet_size   (alphabet_size),
    .word_length     (word_length),
    .sequence_length (sequence_length),
    .stat            (wu_stat),
    .word            (wu_word)
  );

  kbh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign word_oor  = CMP_W'(wu_word) >= CMP_W'(TABLE_DEPTH);
  assign sel_ok    = 32'(sel_q) < 32'(TABLE_DEPTH);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    oor_next      = oor_q;
    ram_we        = 1'b0;
    ram_waddr     = clr_addr;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(req.bucket_select);
    wu_ctrl       = '0;
    load_rsp      = 1'b0;
    rsp_next      = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          oor_next = 1'b0;
          if (req.operation == OP_READ) begin
            ram_re     = 1'b1;
            state_next = ST_DONE;
          end else begin
            wu_ctrl.push = 1'b1;
            state_next   = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        ram_raddr = ADDR_W'(wu_word);
        if (!wu_stat.eval) begin
          state_next = ST_DONE;
        end else if (!wu_stat.done) begin
          wu_ctrl.step = 1'b1;
        end else begin
          if (word_oor) begin
            oor_next = 1'b1;
          end else begin
            ram_re = 1'b1;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (op_q == OP_READ) begin
          rsp_next.bucket_index = sel_q;
          if (sel_ok) begin
            rsp_next.bin_count = ram_rdata;
          end else begin
            rsp_next.out_of_range = 1'b1;
          end
        end else if (wu_stat.eval) begin
          if (oor_q) begin
            rsp_next.out_of_range = 1'b1;
          end else begin
            rsp_next.bucket_index = INDEX_W'(wu_word);
            rsp_next.counted      = wu_stat.first_ok;
            rsp_next.bin_count    = wu_stat.first_ok ? sat_inc(ram_rdata) : ram_rdata;
          end
        end
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          ram_we     = rsp_next.counted;
          ram_waddr  = ADDR_W'(wu_word);
          ram_wdata  = rsp_next.bin_count;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      oor_q     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      oor_q    <= oor_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.operation;
      sel_q <= req.bucket_select;
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  `KBH_ASSERT_NOW(a_counted_in_range, rsp_valid && rsp.counted, !rsp.out_of_range, "counted item flagged out of range")
  `KBH_ASSERT_NOW(a_counted_nonzero, rsp_valid && rsp.counted, rsp.bin_count != '0, "counted item reports an empty bin")
  `KBH_ASSERT_NEXT(a_push_loads_steps, wu_ctrl.push, !wu_stat.done && state == ST_MAC, "push did not load the step count")

endmodule

/* rtl/kbh_ram.sv */
// Generic simple dual-port RAM with registered read data.
module kbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/kbh_word_unit.sv */
// Symbol window, position counter and iterative word-number accumulator.
module kbh_word_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  kbh_pkg::word_ctrl_t               ctrl,
  input  logic signed [kbh_pkg::SYM_W-1:0]  symbol,
  input  logic [kbh_pkg::ALPHA_W-1:0]       alphabet_size,
  input  logic [kbh_pkg::WLEN_W-1:0]        word_length,
  input  logic [kbh_pkg::SEQ_W-1:0]         sequence_length,
  output kbh_pkg::word_stat_t               stat,
  output logic [kbh_pkg::WORD_W-1:0]        word
);
  import kbh_pkg::*;

  logic signed [SYM_W-1:0] window      [MAX_WORD];
  logic signed [SYM_W-1:0] window_next [MAX_WORD];
  logic [SEQ_W-1:0]        pos;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        wl;
  logic [WORD_W-1:0]       acc;
  logic                    eval;
  logic                    first_ok;
  logic                    eval_next;
  logic                    first_ok_next;
  logic signed [SYM_W-1:0] first;
  logic signed [SYM_W-1:0] digit;
  logic [ALPHA_W-1:0]      digit_val;
  logic                    pos_sat;
  logic                    filled;
  logic                    start_ok;

  always_comb begin
    window_next[0] = symbol;
    for (int k = 1; k < MAX_WORD; k++) begin
      window_next[k] = window[k-1];
    end
  end

  always_comb begin
    if (word_length == '0) begin
      wl = CNT_W'(1);
    end else if (32'(word_length) > 32'(MAX_WORD)) begin
      wl = CNT_W'(MAX_WORD);
    end else begin
      wl = CNT_W'(word_length);
    end
  end

  // oldest symbol of the window after this push
  assign first = window_next[WIN_IDX_W'(wl - CNT_W'(1))];
  assign first_ok_next = !first[SYM_W-1] && (first != '0) &&
                         (first[ALPHA_W-1:0] < alphabet_size);

  assign pos_sat  = &pos;
  assign filled   = ({1'b0, pos} + (SEQ_W+1)'(1)) >= (SEQ_W+1)'(wl);
  // start + 1 = pos - wl + 2
  assign start_ok = ({1'b0, pos} + (SEQ_W+1)'(2) - (SEQ_W+1)'(wl)) <
                    {1'b0, sequence_length};
  assign eval_next = !pos_sat && filled && start_ok;

  // Horner step, oldest symbol first; non-positive symbols add nothing
  assign digit     = window[WIN_IDX_W'(cnt - CNT_W'(1))];
  assign digit_val = (!digit[SYM_W-1] && digit != '0) ? digit[ALPHA_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_WORD; k++) begin
        window[k] <= '0;
      end
      pos      <= '0;
      cnt      <= '0;
      eval     <= 1'b0;
      first_ok <= 1'b0;
    end else if (ctrl.push) begin
      window   <= window_next;
      if (!pos_sat) begin
        pos <= pos + SEQ_W'(1);
      end
      cnt      <= wl;
      eval     <= eval_next;
      first_ok <= first_ok_next;
    end else if (ctrl.step && cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      acc <= '0;
    end else if (ctrl.step && cnt != '0) begin
      acc <= WORD_W'(acc * WORD_W'(alphabet_size)) + WORD_W'(digit_val);
    end
  end

  assign stat.eval     = eval;
  assign stat.first_ok = first_ok;
  assign stat.done     = (cnt == '0);
  assign word          = acc;

endmodule
